### src/hbrp_pkg.sv
package hbrp_pkg;

	// Default offset width and decoupling queue depth
	localparam int OFFSET_BITS_DEF = 48;
	localparam int QUEUE_DEPTH     = 4;

	// Fixed port field widths
	localparam int SIZE_BITS  = 48;
	localparam int COUNT_BITS = 16;

	// Header byte word
	typedef struct packed {
		logic [7:0]           header_byte;
		logic                 is_last;
		logic [SIZE_BITS-1:0] file_size;
	} hdr_word_t;

	// Result word
	typedef struct packed {
		logic                  is_final;
		logic [SIZE_BITS-1:0]  range_start;
		logic [SIZE_BITS-1:0]  range_end;
		logic [1:0]            status;
		logic [COUNT_BITS-1:0] range_count;
	} res_word_t;

	// Status codes
	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_NONE      = 2'd1;
	localparam logic [1:0] STATUS_MALFORMED = 2'd2;

	// Part parse phase
	typedef enum logic [1:0] {
		PH_SPACES,
		PH_FIRST,
		PH_SECOND,
		PH_SUFFIX
	} phase_t;

	// Control half of a queued job
	typedef struct packed {
		logic has_range;   // close a part: compute and clip a range
		logic suffix;      // part was -suffix form
		logic digit_seen;  // a number follows the dash
		logic is_final;    // emit closing status after the range
		logic malformed;   // header flagged malformed
	} job_ctl_t;

	// Characters
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [2:0] PREFIX_LEN = 3'd6;

	// Expected byte of the "bytes=" prefix at a position
	function automatic logic [7:0] prefix_char(input logic [2:0] pos);
		logic [7:0] c;
		case (pos)
			3'd0:    c = 8'h62; // b
			3'd1:    c = 8'h79; // y
			3'd2:    c = 8'h74; // t
			3'd3:    c = 8'h65; // e
			3'd4:    c = 8'h73; // s
			3'd5:    c = 8'h3D; // =
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

### src/http_byte_range_parser.sv
// Path: a range word is registered in the job queue, the bound stage and the output
// register after the byte that closes its part; the status word follows it.
// Throughput: one header byte per cycle; the back end emits one word a cycle while
// res_stall is low, and a byte stalls only while the 4-entry job queue is full.
// Reset: asynchronous, active low; clears parse state, queue and counter.
module http_byte_range_parser #(
	parameter int OFFSET_BITS = hbrp_pkg::OFFSET_BITS_DEF,
	parameter int QDEPTH      = hbrp_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                hdr_valid,
	output logic                hdr_stall,
	input  hbrp_pkg::hdr_word_t hdr_data,
	output logic                res_valid,
	input  logic                res_stall,
	output hbrp_pkg::res_word_t res_data
);
	import hbrp_pkg::*;

	localparam int JW = $bits(job_ctl_t) + 3 * OFFSET_BITS;

	logic                   take;
	logic                   push;
	logic                   pop;
	logic                   q_full;
	logic                   q_valid;
	job_ctl_t               f_ctl;
	logic [OFFSET_BITS-1:0] f_first, f_acc, f_size;
	job_ctl_t               q_ctl;
	logic [OFFSET_BITS-1:0] q_first, q_acc, q_size;
	logic [JW-1:0]          q_wdata, q_rdata;

	assign hdr_stall = q_full;
	assign take      = hdr_valid && !q_full;
	assign q_wdata   = {f_ctl, f_first, f_acc, f_size};
	assign {q_ctl, q_first, q_acc, q_size} = q_rdata;

	hbrp_front #(.OB(OFFSET_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.hdr_data  (hdr_data),
		.push      (push),
		.job_ctl   (f_ctl),
		.job_first (f_first),
		.job_acc   (f_acc),
		.job_size  (f_size)
	);

	hbrp_queue #(.WIDTH(JW), .DEPTH(QDEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wdata     (q_wdata),
		.pop       (pop),
		.rdata     (q_rdata),
		.full      (q_full),
		.not_empty (q_valid)
	);

	hbrp_back #(.OB(OFFSET_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_ctl     (q_ctl),
		.q_first   (q_first),
		.q_acc     (q_acc),
		.q_size    (q_size),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

endmodule

### src/hbrp_front.sv
module hbrp_front #(
	parameter int OB = 48
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  hbrp_pkg::hdr_word_t  hdr_data,
	output logic                 push,
	output hbrp_pkg::job_ctl_t   job_ctl,
	output logic [OB-1:0]        job_first,
	output logic [OB-1:0]        job_acc,
	output logic [OB-1:0]        job_size
);
	import hbrp_pkg::*;

	phase_t        phase_q;
	logic [2:0]    prefix_q;
	logic [OB-1:0] acc_q;
	logic [OB-1:0] first_q;
	logic          digit_q;
	logic          mal_q;
	logic [OB-1:0] size_q;

	phase_t        phase_d;
	logic [2:0]    prefix_d;
	logic [OB-1:0] acc_d;
	logic [OB-1:0] first_d;
	logic          digit_d;
	logic          mal_d;
	logic [OB-1:0] size_d;
	logic          ev_range;
	logic          ev_final;

	logic [OB+SIZE_BITS-1:0] size_wide;
	logic [OB+3:0]           prod;
	logic [7:0]              b;
	logic [3:0]              dval;

	assign size_wide = {{OB{1'b0}}, hdr_data.file_size};
	assign b         = hdr_data.header_byte;
	assign dval      = 4'(b - CH_ZERO);

	// Next parse state and job capture for one byte
	always_comb begin
		phase_d  = phase_q;
		prefix_d = prefix_q;
		acc_d    = acc_q;
		first_d  = first_q;
		digit_d  = digit_q;
		mal_d    = mal_q;
		size_d   = size_q;
		ev_range = 1'b0;
		ev_final = 1'b0;
		job_ctl  = '0;
		job_first = first_q;
		job_acc   = acc_q;
		prod      = '0;

		// latch size on the first byte of a header
		if (prefix_q == 3'd0 && !mal_q) begin
			size_d = size_wide[OB-1:0];
		end
		job_size = size_d;

		if (!mal_q) begin
			if (prefix_q < PREFIX_LEN) begin
				if (b == prefix_char(prefix_q)) begin
					prefix_d = prefix_q + 3'd1;
				end else begin
					mal_d = 1'b1;
				end
			end else if (b >= CH_ZERO && b <= CH_NINE) begin
				if (phase_q == PH_SPACES) begin
					phase_d = PH_FIRST;
					acc_d   = '0;
					digit_d = 1'b0;
				end
				prod = (OB+4)'({acc_d, 3'b000}) + (OB+4)'({acc_d, 1'b0}) + (OB+4)'(dval);
				if (prod[OB+3:OB] != 4'd0) begin
					mal_d = 1'b1;
				end else begin
					acc_d   = prod[OB-1:0];
					digit_d = 1'b1;
				end
			end else if (b == CH_SPACE) begin
				if (phase_q != PH_SPACES) mal_d = 1'b1;
			end else if (b == CH_DASH) begin
				if (phase_q == PH_SPACES || phase_q == PH_FIRST) begin
					first_d = acc_q;
					phase_d = (phase_q == PH_SPACES) ? PH_SUFFIX : PH_SECOND;
					acc_d   = '0;
					digit_d = 1'b0;
				end else begin
					mal_d = 1'b1;
				end
			end else if (b == CH_COMMA) begin
				// close the part
				if (phase_q == PH_SECOND || (phase_q == PH_SUFFIX && digit_q)) begin
					ev_range           = 1'b1;
					job_ctl.has_range  = 1'b1;
					job_ctl.suffix     = (phase_q == PH_SUFFIX);
					job_ctl.digit_seen = digit_q;
				end else begin
					mal_d = 1'b1;
				end
				phase_d = PH_SPACES;
				acc_d   = '0;
				digit_d = 1'b0;
			end else begin
				mal_d = 1'b1;
			end
		end

		if (hdr_data.is_last) begin
			// close the final part, then the header
			if (!mal_d) begin
				if (prefix_d < PREFIX_LEN) begin
					mal_d = 1'b1;
				end else if (phase_d == PH_SECOND || (phase_d == PH_SUFFIX && digit_d)) begin
					ev_range           = 1'b1;
					job_ctl.has_range  = 1'b1;
					job_ctl.suffix     = (phase_d == PH_SUFFIX);
					job_ctl.digit_seen = digit_d;
					job_first          = first_d;
					job_acc            = acc_d;
				end else begin
					mal_d = 1'b1;
				end
			end
			ev_final          = 1'b1;
			job_ctl.is_final  = 1'b1;
			job_ctl.malformed = mal_d;
			phase_d  = PH_SPACES;
			prefix_d = 3'd0;
			acc_d    = '0;
			first_d  = '0;
			digit_d  = 1'b0;
			mal_d    = 1'b0;
			size_d   = '0;
		end
	end

	assign push = take && (ev_range || ev_final);

	// Advance parse state on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SPACES;
			prefix_q <= 3'd0;
			acc_q    <= '0;
			first_q  <= '0;
			digit_q  <= 1'b0;
			mal_q    <= 1'b0;
			size_q   <= '0;
		end else if (take) begin
			phase_q  <= phase_d;
			prefix_q <= prefix_d;
			acc_q    <= acc_d;
			first_q  <= first_d;
			digit_q  <= digit_d;
			mal_q    <= mal_d;
			size_q   <= size_d;
		end
	end

endmodule

### src/hbrp_queue.sv
module hbrp_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             not_empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rdata     = mem[rd_ptr_q];

	// Write the entry
	always_ff @(posedge clk) begin
		if (push) mem[wr_ptr_q] <= wdata;
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (pop)  rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (push && !pop)      count_q <= count_q + CW'(1);
			else if (pop && !push) count_q <= count_q - CW'(1);
		end
	end

endmodule

### src/hbrp_back.sv
module hbrp_back #(
	parameter int OB = 48
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  hbrp_pkg::job_ctl_t   q_ctl,
	input  logic [OB-1:0]        q_first,
	input  logic [OB-1:0]        q_acc,
	input  logic [OB-1:0]        q_size,
	output logic                 pop,
	output logic                 res_valid,
	input  logic                 res_stall,
	output hbrp_pkg::res_word_t  res_data
);
	import hbrp_pkg::*;

	// Stage 1: clipped bounds
	logic          valid_s1;
	job_ctl_t      ctl_s1;
	logic [OB-1:0] lo_s1;
	logic [OB:0]   hi_s1;
	logic          range_done_q;

	logic [OB-1:0] lo_d;
	logic [OB:0]   hi_d;
	logic [OB:0]   hi_raw;
	logic [OB:0]   size_x;

	logic [COUNT_BITS-1:0] count_q;
	logic [COUNT_BITS-1:0] count_inc;
	logic                  out_valid_q;
	res_word_t             out_q;

	logic emit_r, emit_f, load, s1_done, s1_ready;
	logic [OB+SIZE_BITS-1:0] lo_w;
	logic [OB+SIZE_BITS:0]   hi_w;

	// Compute range bounds from the queue head
	always_comb begin
		size_x = {1'b0, q_size};
		hi_raw = q_ctl.digit_seen ? ({1'b0, q_acc} + (OB+1)'(1)) : size_x;
		if (q_ctl.suffix) begin
			lo_d = (q_acc > q_size) ? '0 : q_size - q_acc;
			hi_d = size_x;
		end else begin
			lo_d = q_first;
			hi_d = (hi_raw > size_x) ? size_x : hi_raw;
		end
	end

	// Sequence range and status words into the output register
	assign emit_r   = valid_s1 && ctl_s1.has_range && ({1'b0, lo_s1} < hi_s1) && !range_done_q;
	assign emit_f   = valid_s1 && ctl_s1.is_final && !emit_r;
	assign load     = (!out_valid_q || !res_stall) && (emit_r || emit_f);
	assign s1_done  = valid_s1 && ((!emit_r && !emit_f) || (load && !(emit_r && ctl_s1.is_final)));
	assign s1_ready = !valid_s1 || s1_done;
	assign pop      = q_valid && s1_ready;

	assign count_inc = (count_q != {COUNT_BITS{1'b1}}) ? count_q + COUNT_BITS'(1) : count_q;
	assign lo_w      = {{SIZE_BITS{1'b0}}, lo_s1};
	assign hi_w      = {{SIZE_BITS{1'b0}}, hi_s1};

	// Hold stage 1 until its words are out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			range_done_q <= 1'b0;
		end else begin
			if (s1_ready) valid_s1 <= q_valid;
			if (s1_done) range_done_q <= 1'b0;
			else if (load && emit_r) range_done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ctl_s1 <= q_ctl;
			lo_s1  <= lo_d;
			hi_s1  <= hi_d;
		end
	end

	// Output register and range counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			if (load) out_valid_q <= 1'b1;
			else if (!res_stall) out_valid_q <= 1'b0;
			if (load && emit_r) count_q <= count_inc;
			else if (load && emit_f) count_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (emit_r) begin
				out_q.is_final    <= 1'b0;
				out_q.range_start <= lo_w[SIZE_BITS-1:0];
				out_q.range_end   <= hi_w[SIZE_BITS-1:0];
				out_q.status      <= STATUS_OK;
				out_q.range_count <= count_inc;
			end else begin
				out_q.is_final    <= 1'b1;
				out_q.range_start <= '0;
				out_q.range_end   <= '0;
				out_q.status      <= ctl_s1.malformed ? STATUS_MALFORMED :
				                     ((count_q != '0) ? STATUS_OK : STATUS_NONE);
				out_q.range_count <= count_q;
			end
		end
	end

	assign res_valid = out_valid_q;
	assign res_data  = out_q;

	// A range word is never empty
	a_range_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(load && emit_r) |=> (out_q.range_start < out_q.range_end))
		else $error("empty range emitted");

	// A split job is always a closing one
	a_split_final: assert property (@(posedge clk) disable iff (!arst_n)
		range_done_q |-> (valid_s1 && ctl_s1.is_final))
		else $error("range done on a non-final job");

	// Counter clears after the status word
	a_count_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(load && emit_f) |=> (count_q == '0))
		else $error("range count not cleared");

	// No word is overwritten while stalled
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_stall) |-> !load)
		else $error("output word overwritten");

endmodule
